>>> hdl/sacr_pkg.sv
// ----------------------------------------------------------------------------
// sacr_pkg
// types, constants and helpers shared by the set-associative cache model
// ----------------------------------------------------------------------------
package sacr_pkg;

    localparam int SET_BITS = 6;
    localparam int WAY_BITS = 2;

    localparam int ADDR_W    = 32;
    localparam int CNT_W     = 32;
    localparam int KEY_W     = ADDR_W - 2;
    localparam int NUM_SETS  = 1 << SET_BITS;
    localparam int NUM_WAYS  = 1 << WAY_BITS;
    localparam int WAY_W     = (WAY_BITS > 0) ? WAY_BITS : 1;
    localparam int SLOT_W    = KEY_W + 1;
    localparam int ROW_W     = NUM_WAYS * SLOT_W;
    localparam int LFSR_W    = 16;

    localparam logic [ADDR_W-1:0] ALIGN_MASK = 32'hFFFF_FFFC;
    localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;

    typedef logic [KEY_W-1:0]    t_key;
    typedef logic [SET_BITS-1:0] t_set;
    typedef logic [WAY_W-1:0]    t_way;
    typedef logic [ROW_W-1:0]    t_row;
    typedef logic [LFSR_W-1:0]   t_lfsr;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // lookup status from the tag compare
    typedef struct packed {
        logic hit;
        logic full;
    } t_match;

    // fibonacci step, taps 16 14 13 11
    function automatic t_lfsr lfsr_advance(input t_lfsr v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

endpackage

>>> hdl/sacr_req_if.sv
// ----------------------------------------------------------------------------
// sacr_req_if
// request channel: one access address per word
// ----------------------------------------------------------------------------
interface sacr_req_if;
    logic                          valid;
    logic                          ready;
    logic [sacr_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

>>> hdl/sacr_rsp_if.sv
// ----------------------------------------------------------------------------
// sacr_rsp_if
// response channel: hit flag and running totals per word
// ----------------------------------------------------------------------------
interface sacr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [sacr_pkg::CNT_W-1:0]   hit_total;
    logic [sacr_pkg::CNT_W-1:0]   miss_total;

    modport source (output valid, output hit, output hit_total, output miss_total,
                    input ready);
    modport sink   (input valid, input hit, input hit_total, input miss_total,
                    output ready);
endinterface

>>> hdl/sacr_ram.sv
// ----------------------------------------------------------------------------
// sacr_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/sacr_match.sv
// ----------------------------------------------------------------------------
// sacr_match
// parallel tag compare over one set row, fill/victim choice and row update
// ----------------------------------------------------------------------------
module sacr_match (
    input  sacr_pkg::t_row   i_row,
    input  sacr_pkg::t_key   i_key,
    input  sacr_pkg::t_way   i_victim,
    output sacr_pkg::t_match o_match,
    output sacr_pkg::t_row   o_row
);

    logic                          hit;
    logic                          have_free;
    sacr_pkg::t_way                free_way;
    sacr_pkg::t_way                target;
    logic [sacr_pkg::SLOT_W-1:0]   slot;

    always_comb begin
        hit       = 1'b0;
        have_free = 1'b0;
        free_way  = '0;
        slot      = '0;
        for (int w = 0; w < sacr_pkg::NUM_WAYS; w++) begin
            slot = i_row[w*sacr_pkg::SLOT_W +: sacr_pkg::SLOT_W];
            if (slot[sacr_pkg::KEY_W]) begin
                if (slot[sacr_pkg::KEY_W-1:0] == i_key) begin
                    hit = 1'b1;
                end
            end else if (!have_free) begin
                have_free = 1'b1;
                free_way  = sacr_pkg::t_way'(w);
            end
        end
    end

    // lowest free way first, else the random victim
    assign target = have_free ? free_way : i_victim;

    always_comb begin
        o_row = i_row;
        o_row[target*sacr_pkg::SLOT_W +: sacr_pkg::SLOT_W] = {1'b1, i_key};
    end

    assign o_match.hit  = hit;
    assign o_match.full = !have_free;

endmodule

>>> hdl/set_assoc_cache_random_replace.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_random_replace
// hit/miss tracker of a set-associative cache with lfsr victim choice
// ----------------------------------------------------------------------------
//
//  channel  dir  modport  payload
//  i_req    in   sink     address[31:0]
//  o_rsp    out  source   hit, hit_total[31:0], miss_total[31:0]
//
//  each word takes one ram read of the set row in idle, then compare,
//  result load and, on a miss, write-back in lookup; the read of the set
//  row and its write-back do not overlap between words
//  after reset a clearing pass writes every set row (NUM_SETS, 64 at the
//  default size), with i_req.ready low
//  a waiting result does not block the next read; the compare step holds
//  only while the output register is full and not being taken
//
module set_assoc_cache_random_replace (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sacr_req_if.sink          i_req,
    sacr_rsp_if.source        o_rsp
);

    // state and per-word registers
    sacr_pkg::t_state  r_state, n_state;
    sacr_pkg::t_set    r_clr_idx;
    sacr_pkg::t_set    r_set;
    sacr_pkg::t_key    r_key;
    sacr_pkg::t_lfsr   r_lfsr;
    sacr_pkg::t_cnt    r_hit_cnt;
    sacr_pkg::t_cnt    r_miss_cnt;
    logic              r_out_valid;
    logic              r_hit;

    // ram control
    logic              ram_we;
    sacr_pkg::t_set    ram_waddr;
    sacr_pkg::t_row    ram_wdata;
    logic              ram_re;
    sacr_pkg::t_row    ram_rdata;

    // datapath
    logic [sacr_pkg::ADDR_W-1:0] aligned;
    sacr_pkg::t_set    in_set;
    sacr_pkg::t_lfsr   lfsr_next;
    sacr_pkg::t_way    victim;
    sacr_pkg::t_match  match;
    sacr_pkg::t_row    new_row;
    logic              accept;
    logic              go;
    logic              clr_last;

    // address split: word-aligned key, set index above the way bits
    assign aligned   = i_req.address & sacr_pkg::ALIGN_MASK;
    assign in_set    = aligned[sacr_pkg::WAY_BITS +: sacr_pkg::SET_BITS];

    // victim comes from the advanced lfsr value
    assign lfsr_next = sacr_pkg::lfsr_advance(r_lfsr);
    assign victim    = lfsr_next[sacr_pkg::WAY_W-1:0]
                       & sacr_pkg::t_way'(sacr_pkg::NUM_WAYS - 1);

    assign accept    = i_req.valid && i_req.ready;
    assign clr_last  = (r_clr_idx == sacr_pkg::t_set'(sacr_pkg::NUM_SETS - 1));

    // one row per set: {valid, key} per way
    sacr_ram #(
        .WIDTH (sacr_pkg::ROW_W),
        .DEPTH (sacr_pkg::NUM_SETS)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (in_set),
        .o_rdata (ram_rdata)
    );

    sacr_match u_match (
        .i_row    (ram_rdata),
        .i_key    (r_key),
        .i_victim (victim),
        .o_match  (match),
        .o_row    (new_row)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sacr_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = sacr_pkg::ST_IDLE;
                end
            end
            sacr_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = sacr_pkg::ST_LOOKUP;
                end
            end
            sacr_pkg::ST_LOOKUP: begin
                if (go) begin
                    n_state = sacr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sacr_pkg::ST_CLEAR;
            end
        endcase
    end

    // state outputs
    always_comb begin
        i_req.ready = 1'b0;
        ram_re      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_set;
        ram_wdata   = new_row;
        go          = 1'b0;
        case (r_state)
            sacr_pkg::ST_CLEAR: begin
                // invalidate one set row per cycle
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
            end
            sacr_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                ram_re      = i_req.valid;
            end
            sacr_pkg::ST_LOOKUP: begin
                // proceed once the output register can take the result
                go     = !r_out_valid || o_rsp.ready;
                ram_we = go && !match.hit;
            end
            default: begin
                go = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacr_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_lfsr      <= sacr_pkg::LFSR_SEED;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sacr_pkg::ST_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (go) begin
                r_out_valid <= 1'b1;
                if (match.hit) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end else begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                    // lfsr steps only when a full set needs a victim
                    if (match.full) begin
                        r_lfsr <= lfsr_next;
                    end
                end
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set <= in_set;
            r_key <= aligned[sacr_pkg::ADDR_W-1:2];
        end
        if (go) begin
            r_hit <= match.hit;
        end
    end

    // totals only move when a result loads, so the counters are the payload
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.hit        = r_hit;
    assign o_rsp.hit_total  = r_hit_cnt;
    assign o_rsp.miss_total = r_miss_cnt;

    // a result only appears right after a compare step
    a_out_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == sacr_pkg::ST_LOOKUP))
        else $error("result appeared without a lookup");

    // each completed lookup bumps exactly one of the two counters
    a_one_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sacr_pkg::ST_LOOKUP && go) |=>
        (sacr_pkg::CNT_W'(r_hit_cnt + r_miss_cnt)
         == sacr_pkg::CNT_W'($past(r_hit_cnt + r_miss_cnt) + 1'b1)))
        else $error("counters did not advance by one");

    // lfsr moves only on a miss into a full set
    a_lfsr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_lfsr)) |->
        $past(go && !match.hit && match.full))
        else $error("lfsr stepped without a victim choice");

    // no ram write while waiting for a request
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sacr_pkg::ST_IDLE) |-> !ram_we && (accept == ram_re))
        else $error("ram access out of step with the handshake");

endmodule
